// ===== src/text_cell_frame_writer_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef TEXT_CELL_FRAME_WRITER_UNIT_ASSERT_SVH
`define TEXT_CELL_FRAME_WRITER_UNIT_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define TCFW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define TCFW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcfw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcfw_pkg
// shared types and constants of the text cell frame writer
// ----------------------------------------------------------------------------
package tcfw_pkg;

    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_COLS_DEF  = 128;
    localparam int CHAR_BITS_DEF = 16;

    // width for grid compares, covers every legal grid size
    localparam int GRID_W = 10;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [6:0] ROWS_RST = 7'd25;
    localparam logic [7:0] COLS_RST = 8'd80;

    localparam logic [3:0] DEF_FG    = 4'd7;
    localparam logic [3:0] DEF_BG    = 4'd0;
    localparam logic [3:0] COLOR_MAX = 4'd15;

    localparam int NEWLINE_CODE = 10;

    localparam int QDEPTH = 4;

    typedef enum logic [2:0] {
        REQ_CLEAR    = 3'd0,
        REQ_HOME     = 3'd1,
        REQ_POSITION = 3'd2,
        REQ_ATTR     = 3'd3,
        REQ_WRITE    = 3'd4,
        REQ_NEWLINE  = 3'd5,
        REQ_READ     = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef enum logic [1:0] {
        BST_SWEEP,
        BST_IDLE,
        BST_READ,
        BST_DONE
    } back_state_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] row_out;
        logic [6:0] col_out;
        logic       stored;
        logic [3:0] fg;
        logic [3:0] bg;
    } cmd_ctl_t;

    typedef struct packed {
        logic sweeping;
    } back_status_t;

endpackage

// ===== src/tcfw_ram.sv =====
// ----------------------------------------------------------------------------
// tcfw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tcfw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tcfw_front.sv =====
// ----------------------------------------------------------------------------
// tcfw_front
// accepts items, keeps cursor, colors and grid size, issues memory commands
// ----------------------------------------------------------------------------
module tcfw_front
    import tcfw_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int CHAR_BITS = CHAR_BITS_DEF,
    localparam int ROW_W  = $clog2(MAX_ROWS + 1),
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ADDR_W = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            req_type,
    input  logic [7:0]            row_arg,
    input  logic [7:0]            col_arg,
    input  logic signed [7:0]     fg_arg,
    input  logic signed [7:0]     bg_arg,
    input  logic [15:0]           char_code,
    input  logic                  frame_end,
    input  logic                  q_full,
    input  back_status_t          back_st,
    output logic                  q_push,
    output cmd_ctl_t              q_ctl,
    output logic [ADDR_W-1:0]     q_addr,
    output logic [CHAR_BITS-1:0]  q_char
);

    function automatic logic [3:0] clamp_color(input logic signed [7:0] v);
        logic [3:0] res;
        if (v < 0)
        begin
            res = 4'd0;
        end
        else if (v > 8'sd15)
        begin
            res = COLOR_MAX;
        end
        else
        begin
            res = v[3:0];
        end
        return res;
    endfunction

    logic [6:0]       rows_cfg_reg;
    logic [7:0]       cols_cfg_reg;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [3:0]       fg_reg, fg_next;
    logic [3:0]       bg_reg, bg_next;

    logic [GRID_W-1:0] rows_lim, cols_lim;
    logic [GRID_W-1:0] row_x, col_x, col_inc, row_adv;
    logic [GRID_W-1:0] pos_r, pos_c, rd_r, rd_c;
    logic [GRID_W-1:0] row_n, col_n;
    logic [GRID_W-1:0] a_row, a_col;
    logic              in_grid;
    logic [CHAR_BITS-1:0] ch;

    assign in_ready = !q_full && !back_st.sweeping;
    assign q_push   = in_valid && in_ready;

    assign rows_lim = (rows_cfg_reg == 7'd0) ? GRID_W'(1) :
                      (GRID_W'(rows_cfg_reg) > GRID_W'(MAX_ROWS)) ? GRID_W'(MAX_ROWS) :
                      GRID_W'(rows_cfg_reg);
    assign cols_lim = (cols_cfg_reg == 8'd0) ? GRID_W'(1) :
                      (GRID_W'(cols_cfg_reg) > GRID_W'(MAX_COLS)) ? GRID_W'(MAX_COLS) :
                      GRID_W'(cols_cfg_reg);

    assign row_x   = GRID_W'(row_reg);
    assign col_x   = GRID_W'(col_reg);
    assign col_inc = col_x + GRID_W'(1);
    assign row_adv = (row_x < rows_lim) ? row_x + GRID_W'(1) : row_x;
    assign in_grid = (row_x < rows_lim) && (col_x < cols_lim);
    assign ch      = CHAR_BITS'(char_code);

    assign rd_r  = GRID_W'(row_arg);
    assign rd_c  = GRID_W'(col_arg);
    assign pos_r = (rd_r == '0) ? '0 :
                   (rd_r - GRID_W'(1) > rows_lim - GRID_W'(1)) ? rows_lim - GRID_W'(1) :
                   rd_r - GRID_W'(1);
    assign pos_c = (rd_c == '0) ? '0 :
                   (rd_c - GRID_W'(1) > cols_lim - GRID_W'(1)) ? cols_lim - GRID_W'(1) :
                   rd_c - GRID_W'(1);

    always_comb
    begin
        row_n        = row_x;
        col_n        = col_x;
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        a_row        = row_x;
        a_col        = col_x;
        q_ctl.op     = OP_NONE;
        q_ctl.stored = 1'b0;
        unique case (req_t'(req_type))
            REQ_CLEAR:
            begin
                row_n    = '0;
                col_n    = '0;
                fg_next  = DEF_FG;
                bg_next  = DEF_BG;
                q_ctl.op = OP_CLEAR;
            end
            REQ_HOME:
            begin
                row_n = '0;
                col_n = '0;
            end
            REQ_POSITION:
            begin
                row_n = pos_r;
                col_n = pos_c;
            end
            REQ_ATTR:
            begin
                fg_next = clamp_color(fg_arg);
                bg_next = clamp_color(bg_arg);
            end
            REQ_WRITE:
            begin
                if (ch == CHAR_BITS'(NEWLINE_CODE))
                begin
                    row_n = row_adv;
                    col_n = '0;
                end
                else if (in_grid)
                begin
                    q_ctl.op     = OP_WRITE;
                    q_ctl.stored = 1'b1;
                    if (col_inc >= cols_lim)
                    begin
                        row_n = row_adv;
                        col_n = '0;
                    end
                    else
                    begin
                        col_n = col_inc;
                    end
                end
            end
            REQ_NEWLINE:
            begin
                row_n = row_adv;
                col_n = '0;
            end
            REQ_READ:
            begin
                a_row = rd_r;
                a_col = rd_c;
                if ((rd_r < rows_lim) && (rd_c < cols_lim))
                begin
                    q_ctl.op = OP_READ;
                end
            end
            default:
            begin
            end
        endcase
        // end of frame pulls the row back into the grid
        if (frame_end && (row_n > rows_lim - GRID_W'(1)))
        begin
            row_n = rows_lim - GRID_W'(1);
        end
        row_next      = ROW_W'(row_n);
        col_next      = COL_W'(col_n);
        q_ctl.row_out = 7'(row_n);
        q_ctl.col_out = 7'(col_n);
        q_ctl.fg      = fg_reg;
        q_ctl.bg      = bg_reg;
    end

    assign q_addr = ADDR_W'(ADDR_W'(a_row) * ADDR_W'(MAX_COLS) + ADDR_W'(a_col));
    assign q_char = ch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= ROWS_RST;
            cols_cfg_reg <= COLS_RST;
            row_reg      <= '0;
            col_reg      <= '0;
            fg_reg       <= DEF_FG;
            bg_reg       <= DEF_BG;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROWS: rows_cfg_reg <= cfg_data[6:0];
                    CFG_COLS: cols_cfg_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (q_push)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                fg_reg  <= fg_next;
                bg_reg  <= bg_next;
            end
        end
    end

endmodule

// ===== src/tcfw_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tcfw_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module tcfw_cmd_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/tcfw_back.sv =====
// ----------------------------------------------------------------------------
// tcfw_back
// executes memory commands on the cell store and drives the result register
// ----------------------------------------------------------------------------
module tcfw_back
    import tcfw_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int CHAR_BITS = CHAR_BITS_DEF,
    localparam int DEPTH  = MAX_ROWS * MAX_COLS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CELL_W = CHAR_BITS + 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  cmd_ctl_t             q_ctl,
    input  logic [ADDR_W-1:0]    q_addr,
    input  logic [CHAR_BITS-1:0] q_char,
    output logic                 q_pop,
    output back_status_t         back_st,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [6:0]           cursor_row_out,
    output logic [6:0]           cursor_col_out,
    output logic [15:0]          cell_char,
    output logic [3:0]           cell_fg,
    output logic [3:0]           cell_bg,
    output logic                 stored
);

    localparam logic [CELL_W-1:0] BLANK = {CHAR_BITS'(0), DEF_FG, DEF_BG};

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic              sweep_cmd_reg, sweep_cmd_next;
    cmd_ctl_t          hold_reg, hold_next;

    logic              out_valid_reg, out_valid_next;
    logic [6:0]        row_out_reg, col_out_reg;
    logic [15:0]       char_out_reg;
    logic [3:0]        fg_out_reg, bg_out_reg;
    logic              stored_out_reg;

    logic              slot_free, load;
    cmd_ctl_t          load_ctl;
    logic [CELL_W-1:0] load_cell;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    tcfw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_addr),
        .rdata (ram_rdata)
    );

    assign slot_free        = !out_valid_reg || out_ready;
    assign back_st.sweeping = (state_reg == BST_SWEEP);

    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_cmd_next  = sweep_cmd_reg;
        hold_next       = hold_reg;
        q_pop           = 1'b0;
        load            = 1'b0;
        load_ctl        = q_ctl;
        load_cell       = '0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = q_addr;
        ram_wdata       = {q_char, q_ctl.fg, q_ctl.bg};
        unique case (state_reg)
            BST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_addr_reg;
                ram_wdata = BLANK;
                if (sweep_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next      = sweep_cmd_reg ? BST_DONE : BST_IDLE;
                    sweep_addr_next = '0;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                end
            end
            BST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    unique case (q_ctl.op)
                        OP_WRITE:
                        begin
                            ram_we = 1'b1;
                            load   = 1'b1;
                        end
                        OP_READ:
                        begin
                            ram_re     = 1'b1;
                            hold_next  = q_ctl;
                            state_next = BST_READ;
                        end
                        OP_CLEAR:
                        begin
                            hold_next       = q_ctl;
                            sweep_addr_next = '0;
                            sweep_cmd_next  = 1'b1;
                            state_next      = BST_SWEEP;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            BST_READ:
            begin
                load_ctl  = hold_reg;
                load_cell = ram_rdata;
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = BST_IDLE;
                end
            end
            BST_DONE:
            begin
                load_ctl = hold_reg;
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = BST_IDLE;
                end
            end
            default:
            begin
                state_next = BST_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BST_SWEEP;
            sweep_addr_reg <= '0;
            sweep_cmd_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_cmd_reg  <= sweep_cmd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (load)
        begin
            row_out_reg    <= load_ctl.row_out;
            col_out_reg    <= load_ctl.col_out;
            stored_out_reg <= load_ctl.stored;
            char_out_reg   <= 16'(load_cell[CELL_W-1:8]);
            fg_out_reg     <= load_cell[7:4];
            bg_out_reg     <= load_cell[3:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_row_out = row_out_reg;
    assign cursor_col_out = col_out_reg;
    assign cell_char      = char_out_reg;
    assign cell_fg        = fg_out_reg;
    assign cell_bg        = bg_out_reg;
    assign stored         = stored_out_reg;

endmodule

// ===== src/text_cell_frame_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_cell_frame_writer_unit
// character cell text buffer with cursor, colors, clear and cell read-back
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    req_type .. frame_end
// out       output     out_valid / out_ready  cursor_row_out .. stored
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// home, position, attr, write, newline items: one per cycle unless stalled
// read cell: passes the registered read port of the cell store, then the read state
// clear: one cell per cycle through the write port, then the done result
// after reset the store is blanked while in_ready is low
// a stalled output holds the back end; the front keeps taking items until
// the four-entry command queue is full
// ----------------------------------------------------------------------------
module text_cell_frame_writer_unit
    import tcfw_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int CHAR_BITS = CHAR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            req_type,
    input  logic [7:0]            row_arg,
    input  logic [7:0]            col_arg,
    input  logic signed [7:0]     fg_arg,
    input  logic signed [7:0]     bg_arg,
    input  logic [15:0]           char_code,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [6:0]            cursor_row_out,
    output logic [6:0]            cursor_col_out,
    output logic [15:0]           cell_char,
    output logic [3:0]            cell_fg,
    output logic [3:0]            cell_bg,
    output logic                  stored
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CTL_W  = $bits(cmd_ctl_t);
    localparam int Q_W    = CTL_W + ADDR_W + CHAR_BITS;

    logic                 q_push, q_pop, q_full, q_valid;
    cmd_ctl_t             f_ctl, b_ctl;
    logic [ADDR_W-1:0]    f_addr, b_addr;
    logic [CHAR_BITS-1:0] f_char, b_char;
    logic [Q_W-1:0]       q_wdata, q_rdata;
    back_status_t         back_st;

    tcfw_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .CHAR_BITS (CHAR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .row_arg   (row_arg),
        .col_arg   (col_arg),
        .fg_arg    (fg_arg),
        .bg_arg    (bg_arg),
        .char_code (char_code),
        .frame_end (frame_end),
        .q_full    (q_full),
        .back_st   (back_st),
        .q_push    (q_push),
        .q_ctl     (f_ctl),
        .q_addr    (f_addr),
        .q_char    (f_char)
    );

    assign q_wdata = {f_ctl, f_addr, f_char};

    tcfw_cmd_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    assign b_ctl  = q_rdata[Q_W-1 -: CTL_W];
    assign b_addr = q_rdata[CHAR_BITS +: ADDR_W];
    assign b_char = q_rdata[CHAR_BITS-1:0];

    tcfw_back #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .CHAR_BITS (CHAR_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ctl          (b_ctl),
        .q_addr         (b_addr),
        .q_char         (b_char),
        .q_pop          (q_pop),
        .back_st        (back_st),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .cell_char      (cell_char),
        .cell_fg        (cell_fg),
        .cell_bg        (cell_bg),
        .stored         (stored)
    );

endmodule

// ===== src/tcfw_checker.sv =====
// ----------------------------------------------------------------------------
// tcfw_checker
// port level checks of the text cell frame writer, bound to the top level
// ----------------------------------------------------------------------------
`include "text_cell_frame_writer_unit_assert.svh"

module tcfw_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [6:0]            cursor_row_out,
    input logic [6:0]            cursor_col_out,
    input logic [15:0]           cell_char,
    input logic [3:0]            cell_fg,
    input logic [3:0]            cell_bg,
    input logic                  stored
);

    // a stalled result keeps its cursor fields
    `TCFW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(cursor_row_out) && $stable(cursor_col_out),
        "result changed while stalled")

    // cell contents only come back for reads, never with a store
    `TCFW_ASSERT_NOW(a_cell_only_read,
        out_valid && ((cell_char != 16'd0) || (cell_fg != 4'd0) || (cell_bg != 4'd0)),
        !stored, "cell data returned with a store")

    // the store is blanked right after reset, no item taken
    `TCFW_ASSERT_NOW(a_sweep_blocks_in, $rose(rst_n), !in_ready,
        "item taken during reset sweep")

    // nothing comes out at the start of the reset sweep
    `TCFW_ASSERT_NOW(a_sweep_no_out, $rose(rst_n), !out_valid,
        "result shown during reset sweep")

endmodule

bind text_cell_frame_writer_unit tcfw_checker u_tcfw_checker (.*);
